// File: src/cave_majority_stencil_filter_macros.svh
// assertion helpers used by the top filter module
`ifndef CAVE_MAJORITY_STENCIL_FILTER_MACROS_SVH
`define CAVE_MAJORITY_STENCIL_FILTER_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CMSF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define CMSF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/cmsf_pkg.sv
package cmsf_pkg;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int TDATA_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 1'd1;

    localparam logic [CFG_W-1:0] DIM_RESET = 11'd64;

    localparam int OPEN_THRESHOLD = 5;

    localparam int OUT_FIFO_DEPTH = 4;
    localparam int OUT_PTR_W      = 2;
    localparam int OUT_CNT_W      = 3;

    // control flags of the item in the update stage
    typedef struct packed {
        logic       write;
        logic       emit;
        logic       border;
        logic       last;
        logic       cell_bit;
        logic       fwd_hit;
        logic [1:0] fwd_data;
    } s1_flags_t;

    typedef struct packed {
        logic last;
        logic value;
    } out_item_t;

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                              input int unsigned maxv);
        int unsigned r;
        r = 32'(v);
        if (r < 32'd1) r = 32'd1;
        if (r > maxv) r = maxv;
        return r;
    endfunction

endpackage

// File: src/cave_majority_stencil_filter.sv
// One pass of the cave cellular automaton over a binary grid streamed line
// by line: an output cell is 1 when it is off the border and at least five
// of its 3x3 window are open. The block takes one item per clock while not
// stalled; an output item is formed in the update stage from the input item
// that completes its window, and the output stream lags the input by
// line_length+1 items, so line_length+1 pad items (tuser high) after the
// frame flush it. The pace is set by the line store, a single memory read
// on accept and written back by the update stage, with the write forwarded
// to a read of the same column. Input stalls when the four-entry output
// queue, counting the item in the update stage, would be full. After reset
// a clearing pass zeroes the line store, and tready stays low until it ends.
`include "cave_majority_stencil_filter_macros.svh"

module cave_majority_stencil_filter
    import cmsf_pkg::*;
#(
    parameter int MAX_LINE_LEN = 1024,
    parameter int MAX_LINES    = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // config write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // [0] cell_in, rest zero
    input  logic                 s_tuser,   // pad
    // output items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // [0] cell_out, rest zero
    output logic                 m_tlast    // frame_last
);

    localparam int LEN_W  = $clog2(MAX_LINE_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_LINE_LEN);
    localparam int LINE_W = $clog2(MAX_LINES + 1) + 1;

    // clamped dimensions
    logic [LEN_W-1:0]  w_reg;
    logic [LINE_W-1:0] h_reg;

    // stream positions
    logic [LINE_W-1:0] in_line_reg,  in_line_next;
    logic [LEN_W-1:0]  in_cell_reg,  in_cell_next;
    logic [LINE_W-1:0] out_line_reg, out_line_next;
    logic [LEN_W-1:0]  out_cell_reg, out_cell_next;
    logic              started_reg,  started_next;

    // accept stage decode
    logic              s_fire;
    logic              pad;
    logic              noop;
    logic              in_frame;
    logic              lag_reached;
    logic              emit;
    logic [LEN_W:0]    in_cell_inc;
    logic              in_wrap;
    logic [LEN_W:0]    out_cell_inc;
    logic [LINE_W:0]   out_line_inc;
    logic              out_last_cell;
    logic              out_last_line;
    logic              border;
    logic              last;
    logic [ADDR_W-1:0] rd_addr;

    // update stage
    logic              s1_valid_reg;
    s1_flags_t         s1_flags_reg;
    s1_flags_t         s1_flags_next;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [1:0]        store_rd_data;
    logic [1:0]        store_wr_data;
    logic              store_wr_en;
    logic              store_ready;
    logic              cell_value;

    // output queue
    out_item_t            push_item;
    out_item_t            head;
    logic                 fifo_push;
    logic                 fifo_pop;
    logic [OUT_CNT_W-1:0] fifo_count;

    // config registers, kept already clamped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= LEN_W'(clamp_dim(DIM_RESET, MAX_LINE_LEN));
            h_reg <= LINE_W'(clamp_dim(DIM_RESET, MAX_LINES));
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LINE_COUNT:  h_reg <= LINE_W'(clamp_dim(cfg_data, MAX_LINES));
                CFG_LINE_LENGTH: w_reg <= LEN_W'(clamp_dim(cfg_data, MAX_LINE_LEN));
                default:         ;
            endcase
        end
    end

    // room for the item in flight plus the new one, store cleared
    assign s_tready = store_ready
                   && (({1'b0, fifo_count} + (OUT_CNT_W+1)'(s1_valid_reg))
                       < (OUT_CNT_W+1)'(OUT_FIFO_DEPTH));
    assign s_fire   = s_tvalid && s_tready;
    assign pad      = s_tuser;
    assign rd_addr  = in_cell_reg[ADDR_W-1:0];

    always_comb
    begin
        // a pad with nothing pending is dropped without a trace
        noop     = pad && !started_reg && (in_line_reg == '0) && (in_cell_reg == '0);
        in_frame = (in_line_reg < h_reg);

        in_cell_inc = {1'b0, in_cell_reg} + (LEN_W+1)'(1);
        in_wrap     = (in_cell_inc >= {1'b0, w_reg});

        // linear input index has reached line_length+1
        lag_reached = (in_line_reg >= LINE_W'(2))
                   || ((in_line_reg == LINE_W'(1)) && (in_cell_reg != '0))
                   || ((in_line_reg == '0) && (in_cell_reg > w_reg));
        emit = started_reg || lag_reached;

        out_cell_inc  = {1'b0, out_cell_reg} + (LEN_W+1)'(1);
        out_line_inc  = {1'b0, out_line_reg} + (LINE_W+1)'(1);
        out_last_cell = (out_cell_inc >= {1'b0, w_reg});
        out_last_line = (out_line_inc >= {1'b0, h_reg});
        border = (out_line_reg == '0) || out_last_line
              || (out_cell_reg == '0) || out_last_cell;
        // an output line beyond the grid closes the frame too
        last   = (out_last_line && out_last_cell) || (out_line_reg >= h_reg);

        in_line_next  = in_line_reg;
        in_cell_next  = in_cell_reg;
        out_line_next = out_line_reg;
        out_cell_next = out_cell_reg;
        started_next  = started_reg;

        if (s_fire && !noop)
        begin
            if (in_wrap)
            begin
                in_cell_next = '0;
                in_line_next = in_line_reg + LINE_W'(1);
            end
            else
            begin
                in_cell_next = in_cell_inc[LEN_W-1:0];
            end

            if (emit)
            begin
                if (last)
                begin
                    in_line_next  = '0;
                    in_cell_next  = '0;
                    out_line_next = '0;
                    out_cell_next = '0;
                    started_next  = 1'b0;
                end
                else
                begin
                    started_next = 1'b1;
                    if (out_last_cell)
                    begin
                        out_cell_next = '0;
                        out_line_next = out_line_inc[LINE_W-1:0];
                    end
                    else
                    begin
                        out_cell_next = out_cell_inc[LEN_W-1:0];
                    end
                end
            end
        end

        s1_flags_next.write    = in_frame;
        s1_flags_next.emit     = emit;
        s1_flags_next.border   = border;
        s1_flags_next.last     = last;
        s1_flags_next.cell_bit = s_tdata[0] && !pad;
        // column written back this cycle is read again: take the new pair
        s1_flags_next.fwd_hit  = s1_valid_reg && s1_flags_reg.write
                              && (s1_addr_reg == rd_addr);
        s1_flags_next.fwd_data = store_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_line_reg  <= '0;
            in_cell_reg  <= '0;
            out_line_reg <= '0;
            out_cell_reg <= '0;
            started_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            in_line_reg  <= in_line_next;
            in_cell_reg  <= in_cell_next;
            out_line_reg <= out_line_next;
            out_cell_reg <= out_cell_next;
            started_reg  <= started_next;
            s1_valid_reg <= s_fire && !noop;
        end
    end

    // update stage payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_flags_reg <= s1_flags_next;
            s1_addr_reg  <= rd_addr;
        end
    end

    assign store_wr_en = s1_valid_reg && s1_flags_reg.write;

    cmsf_line_store #(
        .DEPTH  (MAX_LINE_LEN),
        .ADDR_W (ADDR_W)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ready   (store_ready),
        .rd_en   (s_fire),
        .rd_addr (rd_addr),
        .rd_data (store_rd_data),
        .wr_en   (store_wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (store_wr_data)
    );

    cmsf_window_eval u_window_eval (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid   (s1_valid_reg),
        .flags   (s1_flags_reg),
        .rd_data (store_rd_data),
        .wr_data (store_wr_data),
        .value   (cell_value)
    );

    assign fifo_push       = s1_valid_reg && s1_flags_reg.emit;
    assign push_item.last  = s1_flags_reg.last;
    assign push_item.value = cell_value;
    assign fifo_pop        = m_tvalid && m_tready;

    cmsf_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_item (push_item),
        .pop       (fifo_pop),
        .not_empty (m_tvalid),
        .head      (head),
        .count     (fifo_count)
    );

    assign m_tdata = {{(TDATA_W-1){1'b0}}, head.value};
    assign m_tlast = head.last;

    `CMSF_ASSERT_IMP(a_queue_room, fifo_push, (fifo_count < OUT_CNT_W'(OUT_FIFO_DEPTH)) || fifo_pop, "output queue overflow")
    `CMSF_ASSERT_NXT(a_noop_dropped, s_fire && noop, !s1_valid_reg, "dropped pad entered update stage")
    `CMSF_ASSERT_NXT(a_frame_restart, s_fire && !noop && emit && last, (in_line_reg == '0) && (in_cell_reg == '0) && !started_reg, "positions not cleared at frame end")
    `CMSF_ASSERT_IMP(a_fwd_same_col, store_wr_en && (s1_addr_reg == rd_addr), s1_flags_next.fwd_hit, "same column read missed forward")

endmodule

// File: src/cmsf_line_store.sv
module cmsf_line_store
    import cmsf_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    output logic              ready,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [1:0]        rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [1:0]        wr_data
);

    logic [1:0]        mem [DEPTH];
    logic [1:0]        q_reg;
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // after reset every column is zeroed once, one per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= 2'b00;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    assign ready   = !clearing_reg;
    assign rd_data = q_reg;

endmodule

// File: src/cmsf_window_eval.sv
module cmsf_window_eval
    import cmsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid,
    input  s1_flags_t  flags,
    input  logic [1:0] rd_data,
    output logic [1:0] wr_data,
    output logic       value
);

    logic [8:0] window_reg;
    logic [8:0] window_next;
    logic [1:0] old_pair;
    logic [2:0] col;
    logic [3:0] ones;

    always_comb
    begin
        old_pair = flags.fwd_hit ? flags.fwd_data : rd_data;
        // bit0 two lines up, bit1 one line up, bit2 current
        col      = {flags.cell_bit, old_pair[0], old_pair[1]};
        wr_data  = {old_pair[0], flags.cell_bit};
        window_next = window_reg;
        if (valid && flags.write)
        begin
            window_next = {window_reg[5:0], col};
        end
        ones  = 4'($countones(window_next));
        value = !flags.border && (ones >= 4'(OPEN_THRESHOLD));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else
        begin
            window_reg <= window_next;
        end
    end

endmodule

// File: src/cmsf_out_fifo.sv
module cmsf_out_fifo
    import cmsf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  out_item_t            push_item,
    input  logic                 pop,
    output logic                 not_empty,
    output out_item_t            head,
    output logic [OUT_CNT_W-1:0] count
);

    out_item_t            entries [OUT_FIFO_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [OUT_CNT_W-1:0] count_reg;
    logic                 do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            end
            case ({push, do_pop})
                2'b10:   count_reg <= count_reg + OUT_CNT_W'(1);
                2'b01:   count_reg <= count_reg - OUT_CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = entries[rd_ptr_reg];
    assign count     = count_reg;

endmodule
